// ----- rtl/code_point_range_set_macros.svh -----
// Assertion macros used by the code point range set datapath.
`ifndef CODE_POINT_RANGE_SET_MACROS_SVH
`define CODE_POINT_RANGE_SET_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset.
`define CPRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property violated");
// Check that a condition never holds outside reset.
`define CPRS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CPRS_ASSERT(lbl, clk, rstn, prop)
`define CPRS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- rtl/cprs_pkg.sv -----
// Shared types and constants of the code point range set.
`timescale 1ns / 1ps
`default_nettype none
package cprs_pkg;

  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] CODE_SPACE_END = 21'd1114112;

  // Operation codes
  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  // Datapath commands issued by the controller, one per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_K,
    CMD_RD_IDX,
    CMD_RD_KM1,
    CMD_RD_AB,
    CMD_L_HIT,
    CMD_SCAN,
    CMD_SKIP,
    CMD_OVF,
    CMD_STOP,
    CMD_SHW,
    CMD_INS,
    CMD_K_INC,
    CMD_IDX_INC,
    CMD_C_COPY,
    CMD_C_CLR,
    CMD_C_MERGE,
    CMD_C_REST,
    CMD_C_FIN,
    CMD_SET_USED,
    CMD_RESULT
  } cmd_e;

  // Status flags from the datapath
  typedef struct packed {
    logic [1:0] op;
    logic       k_lt_used;
    logic       idx_lt_used;
    logic       k_gt_idx;
    logic       idx_eq_k;
    logic       first_lt_last;
    logic       first_lt_a_start;
    logic       full;
    logic       a_len_full;
    logic       a_len_zero;
    logic       b_len_zero;
    logic       touch;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/cprs_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface cprs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [20:0] code_point;
  logic [20:0] range_end;

  modport source (output valid, output op, output code_point, output range_end,
                  input ready);
  modport sink (input valid, input op, input code_point, input range_end,
                output ready);
endinterface

interface cprs_out_if #(
  parameter int unsigned CNT_W = 7
);
  logic             valid;
  logic             ready;
  logic             member;
  logic [20:0]      total_count;
  logic [CNT_W-1:0] entry_count;
  logic             overflow;

  modport source (output valid, output member, output total_count,
                  output entry_count, output overflow, input ready);
  modport sink (input valid, input member, input total_count,
                input entry_count, input overflow, output ready);
endinterface
`default_nettype wire

// ----- rtl/cprs_ctrl.sv -----
// Sequencer of the code point range set: steps lookup, add and compact.
`timescale 1ns / 1ps
`default_nettype none
module cprs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output cprs_pkg::cmd_e     cmd_o,
  input  wire cprs_pkg::sts_t sts_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_L_RD   = 5'd2;
  localparam logic [4:0] S_L_EV   = 5'd3;
  localparam logic [4:0] S_A_SRD  = 5'd4;
  localparam logic [4:0] S_A_SEV  = 5'd5;
  localparam logic [4:0] S_A_LOOP = 5'd6;
  localparam logic [4:0] S_A_EV   = 5'd7;
  localparam logic [4:0] S_A_GAP  = 5'd8;
  localparam logic [4:0] S_A_SH   = 5'd9;
  localparam logic [4:0] S_A_SW   = 5'd10;
  localparam logic [4:0] S_A_WR   = 5'd11;
  localparam logic [4:0] S_C_TOP  = 5'd12;
  localparam logic [4:0] S_C_EV   = 5'd13;
  localparam logic [4:0] S_C_MV2  = 5'd14;
  localparam logic [4:0] S_C_MG2  = 5'd15;
  localparam logic [4:0] S_C_END  = 5'd16;
  localparam logic [4:0] S_C_FIN  = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0] state_q, state_d;

  // Next state and command
  always_comb begin
    state_d    = state_q;
    cmd_o      = cprs_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = cprs_pkg::CMD_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          cprs_pkg::OP_LOOKUP:  state_d = S_L_RD;
          cprs_pkg::OP_ADD:     state_d = S_A_SRD;
          cprs_pkg::OP_COMPACT: state_d = S_C_TOP;
          default:              state_d = S_DONE;
        endcase
      end
      // lookup: walk entries until one starts above the point
      S_L_RD: begin
        if (!sts_i.k_lt_used) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = cprs_pkg::CMD_RD_K;
          state_d = S_L_EV;
        end
      end
      S_L_EV: begin
        if (sts_i.first_lt_a_start) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = cprs_pkg::CMD_L_HIT;
          state_d = S_L_RD;
        end
      end
      // add: find the last entry starting at or below the first point
      S_A_SRD: begin
        if (!sts_i.k_lt_used) begin
          state_d = S_A_LOOP;
        end else begin
          cmd_o   = cprs_pkg::CMD_RD_K;
          state_d = S_A_SEV;
        end
      end
      S_A_SEV: begin
        cmd_o   = cprs_pkg::CMD_SCAN;
        state_d = S_A_SRD;
      end
      S_A_LOOP: begin
        if (!sts_i.first_lt_last) begin
          state_d = S_DONE;
        end else if (sts_i.idx_lt_used) begin
          cmd_o   = cprs_pkg::CMD_RD_IDX;
          state_d = S_A_EV;
        end else begin
          state_d = S_A_GAP;
        end
      end
      S_A_EV: begin
        if (sts_i.first_lt_a_start) begin
          state_d = S_A_GAP;
        end else begin
          cmd_o   = cprs_pkg::CMD_SKIP;
          state_d = S_A_LOOP;
        end
      end
      S_A_GAP: begin
        if (sts_i.full) begin
          cmd_o   = cprs_pkg::CMD_OVF;
          state_d = S_DONE;
        end else begin
          cmd_o   = cprs_pkg::CMD_STOP;
          state_d = S_A_SH;
        end
      end
      // open a hole by moving entries up one place
      S_A_SH: begin
        if (sts_i.k_gt_idx) begin
          cmd_o   = cprs_pkg::CMD_RD_KM1;
          state_d = S_A_SW;
        end else begin
          state_d = S_A_WR;
        end
      end
      S_A_SW: begin
        cmd_o   = cprs_pkg::CMD_SHW;
        state_d = S_A_SH;
      end
      S_A_WR: begin
        cmd_o   = cprs_pkg::CMD_INS;
        state_d = S_A_LOOP;
      end
      // compact: two pointers over the table
      S_C_TOP: begin
        if (!sts_i.k_lt_used) begin
          state_d = S_C_END;
        end else if (sts_i.idx_eq_k) begin
          cmd_o = cprs_pkg::CMD_K_INC;
        end else begin
          cmd_o   = cprs_pkg::CMD_RD_AB;
          state_d = S_C_EV;
        end
      end
      S_C_EV: begin
        state_d = S_C_TOP;
        if (sts_i.a_len_full) begin
          cmd_o = cprs_pkg::CMD_IDX_INC;
        end else if (sts_i.b_len_zero) begin
          cmd_o = cprs_pkg::CMD_K_INC;
        end else if (sts_i.a_len_zero) begin
          cmd_o   = cprs_pkg::CMD_C_COPY;
          state_d = S_C_MV2;
        end else if (sts_i.touch) begin
          cmd_o   = cprs_pkg::CMD_C_MERGE;
          state_d = S_C_MG2;
        end else begin
          cmd_o = cprs_pkg::CMD_IDX_INC;
        end
      end
      S_C_MV2: begin
        cmd_o   = cprs_pkg::CMD_C_CLR;
        state_d = S_C_TOP;
      end
      S_C_MG2: begin
        cmd_o   = cprs_pkg::CMD_C_REST;
        state_d = S_C_TOP;
      end
      S_C_END: begin
        if (sts_i.idx_lt_used) begin
          cmd_o   = cprs_pkg::CMD_RD_IDX;
          state_d = S_C_FIN;
        end else begin
          cmd_o   = cprs_pkg::CMD_SET_USED;
          state_d = S_DONE;
        end
      end
      S_C_FIN: begin
        cmd_o   = cprs_pkg::CMD_C_FIN;
        state_d = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o   = cprs_pkg::CMD_RESULT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cprs_dp.sv -----
// Datapath of the code point range set: range table, pointers and counters.
`timescale 1ns / 1ps
`default_nettype none
`include "code_point_range_set_macros.svh"
module cprs_dp #(
  parameter int unsigned MAX_ENTRIES    = 64,
  parameter int unsigned ENTRY_CAPACITY = 255
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      op_i,
  input  wire logic [20:0]     code_point_i,
  input  wire logic [20:0]     range_end_i,
  cprs_out_if.source           res_o,
  input  wire cprs_pkg::cmd_e  cmd_i,
  output cprs_pkg::sts_t       sts_o
);

  localparam int unsigned CPW = cprs_pkg::CP_W;
  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW  = $clog2(ENTRY_CAPACITY + 1);
  localparam int unsigned EW  = CPW + LW;
  localparam logic [LW-1:0]  CAP_L  = LW'(ENTRY_CAPACITY);
  localparam logic [CPW:0]   CAP_X  = (CPW+1)'(ENTRY_CAPACITY);
  localparam logic [CW-1:0]  MAX_C  = CW'(MAX_ENTRIES);

  // Range table: start in the upper bits, length in the lower bits
  logic [EW-1:0] mem_q [MAX_ENTRIES];
  logic [EW-1:0] rd_a_q, rd_b_q;

  logic [1:0]     op_q;
  logic [CPW-1:0] first_q, last_q, stop_q, total_q;
  logic [CW-1:0]  idx_q, k_q, used_q;
  logic           hit_q, ovf_q;
  logic           out_valid_q, out_member_q, out_ovf_q;
  logic [CPW-1:0] out_total_q;
  logic [CW-1:0]  out_used_q;

  logic [CPW-1:0] a_start, b_start;
  logic [LW-1:0]  a_len, b_len, move, room, ins_len;
  logic [CPW:0]   a_end, first_cap, stop_x;
  logic [CPW-1:0] cp_clamp, re_clamp, stop_v, diff;
  logic [CW-1:0]  k_m1;
  logic           re_a, re_b, we;
  logic [AW-1:0]  ra, rb, wa;
  logic [EW-1:0]  wd;

  assign a_start = rd_a_q[EW-1:LW];
  assign a_len   = rd_a_q[LW-1:0];
  assign b_start = rd_b_q[EW-1:LW];
  assign b_len   = rd_b_q[LW-1:0];
  assign a_end   = {1'b0, a_start} + (CPW+1)'(a_len);
  assign k_m1    = k_q - CW'(1);
  assign diff    = first_q - a_start;
  assign ins_len = LW'(stop_q - first_q);

  // Input clamping to the code space
  assign cp_clamp = (code_point_i > cprs_pkg::CODE_SPACE_END) ?
                    cprs_pkg::CODE_SPACE_END : code_point_i;
  assign re_clamp = (range_end_i > cprs_pkg::CODE_SPACE_END) ?
                    cprs_pkg::CODE_SPACE_END : range_end_i;

  // End of a new entry: capacity, range end, or the next entry
  always_comb begin
    first_cap = {1'b0, first_q} + CAP_X;
    stop_x    = (first_cap > {1'b0, last_q}) ? {1'b0, last_q} : first_cap;
    if (idx_q < used_q && stop_x > {1'b0, a_start}) begin
      stop_x = {1'b0, a_start};
    end
    stop_v = stop_x[CPW-1:0];
  end

  // Points moved from the next entry into the current one
  assign room = CAP_L - a_len;
  assign move = (room > b_len) ? b_len : room;

  // Status to the controller
  always_comb begin
    sts_o.op               = op_q;
    sts_o.k_lt_used        = k_q < used_q;
    sts_o.idx_lt_used      = idx_q < used_q;
    sts_o.k_gt_idx         = k_q > idx_q;
    sts_o.idx_eq_k         = idx_q == k_q;
    sts_o.first_lt_last    = first_q < last_q;
    sts_o.first_lt_a_start = first_q < a_start;
    sts_o.full             = used_q >= MAX_C;
    sts_o.a_len_full       = a_len >= CAP_L;
    sts_o.a_len_zero       = a_len == '0;
    sts_o.b_len_zero       = b_len == '0;
    sts_o.touch            = a_end == {1'b0, b_start};
    sts_o.out_free         = !out_valid_q || res_o.ready;
  end

  // Table port selection
  always_comb begin
    re_a = 1'b0;
    re_b = 1'b0;
    we   = 1'b0;
    ra   = idx_q[AW-1:0];
    rb   = k_q[AW-1:0];
    wa   = idx_q[AW-1:0];
    wd   = rd_a_q;
    case (cmd_i)
      cprs_pkg::CMD_RD_K: begin
        re_a = 1'b1;
        ra   = k_q[AW-1:0];
      end
      cprs_pkg::CMD_RD_IDX: re_a = 1'b1;
      cprs_pkg::CMD_RD_KM1: begin
        re_a = 1'b1;
        ra   = k_m1[AW-1:0];
      end
      cprs_pkg::CMD_RD_AB: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      cprs_pkg::CMD_SHW: begin
        we = 1'b1;
        wa = k_q[AW-1:0];
      end
      cprs_pkg::CMD_INS: begin
        we = 1'b1;
        wd = {first_q, ins_len};
      end
      cprs_pkg::CMD_C_COPY: begin
        we = 1'b1;
        wd = rd_b_q;
      end
      cprs_pkg::CMD_C_CLR: begin
        we = 1'b1;
        wa = k_q[AW-1:0];
        wd = '0;
      end
      cprs_pkg::CMD_C_MERGE: begin
        we = 1'b1;
        wd = {a_start, a_len + move};
      end
      cprs_pkg::CMD_C_REST: begin
        we = 1'b1;
        wa = k_q[AW-1:0];
        wd = {b_start + CPW'(move), b_len - move};
      end
      default: we = 1'b0;
    endcase
  end

  // Range table with registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re_a) begin
      rd_a_q <= mem_q[ra];
    end
    if (re_b) begin
      rd_b_q <= mem_q[rb];
    end
  end

  // Working registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= '0;
      first_q      <= '0;
      last_q       <= '0;
      stop_q       <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      hit_q        <= 1'b0;
      ovf_q        <= 1'b0;
      used_q       <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      out_member_q <= 1'b0;
      out_ovf_q    <= 1'b0;
      out_total_q  <= '0;
      out_used_q   <= '0;
    end else begin
      // a new result takes precedence over the drain of the old one
      if (out_valid_q && res_o.ready && cmd_i != cprs_pkg::CMD_RESULT) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        cprs_pkg::CMD_LOAD: begin
          op_q    <= op_i;
          first_q <= cp_clamp;
          last_q  <= re_clamp;
          idx_q   <= '0;
          k_q     <= '0;
          hit_q   <= 1'b0;
          ovf_q   <= 1'b0;
        end
        cprs_pkg::CMD_L_HIT: begin
          hit_q <= diff < CPW'(a_len);
          k_q   <= k_q + CW'(1);
        end
        cprs_pkg::CMD_SCAN: begin
          if (!(first_q < a_start)) begin
            idx_q <= k_q;
          end
          k_q <= k_q + CW'(1);
        end
        cprs_pkg::CMD_SKIP: begin
          if ({1'b0, first_q} < a_end) begin
            first_q <= (a_end < {1'b0, last_q}) ? a_end[CPW-1:0] : last_q;
          end
          idx_q <= idx_q + CW'(1);
        end
        cprs_pkg::CMD_OVF: ovf_q <= 1'b1;
        cprs_pkg::CMD_STOP: begin
          stop_q <= stop_v;
          k_q    <= used_q;
        end
        cprs_pkg::CMD_SHW: k_q <= k_m1;
        cprs_pkg::CMD_INS: begin
          used_q  <= used_q + CW'(1);
          total_q <= total_q + CPW'(ins_len);
          idx_q   <= idx_q + CW'(1);
          first_q <= stop_q;
        end
        cprs_pkg::CMD_K_INC:    k_q <= k_q + CW'(1);
        cprs_pkg::CMD_IDX_INC:  idx_q <= idx_q + CW'(1);
        cprs_pkg::CMD_C_FIN:    used_q <= idx_q + CW'(a_len != '0);
        cprs_pkg::CMD_SET_USED: used_q <= idx_q;
        cprs_pkg::CMD_RESULT: begin
          out_valid_q  <= 1'b1;
          out_member_q <= hit_q;
          out_ovf_q    <= ovf_q;
          out_total_q  <= total_q;
          out_used_q   <= used_q;
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.member      = out_member_q;
  assign res_o.total_count = out_total_q;
  assign res_o.entry_count = out_used_q;
  assign res_o.overflow    = out_ovf_q;

  `CPRS_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= MAX_C)
  `CPRS_NEVER(a_ins_full, clk_i, rst_ni, cmd_i == cprs_pkg::CMD_INS && used_q >= MAX_C)
  `CPRS_ASSERT(a_ins_count, clk_i, rst_ni, (cmd_i == cprs_pkg::CMD_INS) |=> (used_q == $past(used_q) + CW'(1)))

endmodule
`default_nettype wire

// ----- rtl/code_point_range_set.sv -----
// Top level of the code point range set.
`timescale 1ns / 1ps
`default_nettype none
// Keeps a sorted table of up to MAX_ENTRIES disjoint code point ranges in a
// single-write, dual-read RAM and answers one transaction at a time with one
// result. A lookup walks the entries until one starts above the point. An
// add first searches the table, then for each new piece moves the later
// entries up one place and writes the piece; an existing entry it meets is
// skipped. A compact steps two pointers: they meet, a pair is compared, or a
// copy or merge is made after which the pair is examined again. Each table
// read is registered. The result sits in an output register, so the next
// request is taken while it waits. No clearing pass is needed after reset.
module code_point_range_set #(
  parameter int unsigned MAX_ENTRIES    = 64,
  parameter int unsigned ENTRY_CAPACITY = 255
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cprs_in_if.sink   in_i,
  cprs_out_if.source res_o
);

  cprs_pkg::cmd_e cmd;
  cprs_pkg::sts_t sts;
  logic           in_ready;

  assign in_i.ready = in_ready;

  cprs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cprs_dp #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .ENTRY_CAPACITY (ENTRY_CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (in_i.op),
    .code_point_i (in_i.code_point),
    .range_end_i  (in_i.range_end),
    .res_o        (res_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
`default_nettype wire
